[hw/rtl/subsecond_format_expander_macros.svh]
// Assertion macros for the sub-second format expander.
`ifndef SUBSECOND_FORMAT_EXPANDER_MACROS_SVH
`define SUBSECOND_FORMAT_EXPANDER_MACROS_SVH
`ifndef SYNTH
`define SFE_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("%m: check failed");
`define SFE_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: check failed");
`else
`define SFE_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define SFE_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

[hw/rtl/sfe_pkg.sv]
// Shared types and constants of the sub-second format expander.
`default_nettype none
package sfe_pkg;

  localparam int CHAR_W  = 8;
  localparam int MILLI_W = 10;
  localparam int MICRO_W = 20;
  localparam int NANO_W  = 30;
  localparam int FRAC_W  = NANO_W;
  localparam int DIGIT_W = 4;
  localparam int CNT_W   = 4;

  localparam logic [CHAR_W-1:0] CHAR_PCT  = 8'h25;  // '%'
  localparam logic [CHAR_W-1:0] CHAR_L    = 8'h4C;  // 'L'
  localparam logic [CHAR_W-1:0] CHAR_F    = 8'h66;  // 'f'
  localparam logic [CHAR_W-1:0] CHAR_N    = 8'h4E;  // 'N'
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;  // '0'

  localparam logic [MILLI_W-1:0] MILLI_MAX = 10'd999;
  localparam logic [MICRO_W-1:0] MICRO_MAX = 20'd999999;
  localparam logic [NANO_W-1:0]  NANO_MAX  = 30'd999999999;

  // last digit index for each width
  localparam logic [CNT_W-1:0] MILLI_LAST = 4'd2;
  localparam logic [CNT_W-1:0] MICRO_LAST = 4'd5;
  localparam logic [CNT_W-1:0] NANO_LAST  = 4'd8;
  localparam int               NUM_DIGITS = 9;

  // floor(v / 10) == (v * RECIP10) >> RECIP_SHIFT for any 32-bit v
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          PROD_W      = FRAC_W + 32;
  localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;

  typedef struct packed {
    logic [CHAR_W-1:0]  style_char;
    logic               string_end;
    logic [MILLI_W-1:0] milli_part;
    logic [MICRO_W-1:0] micro_part;
    logic [NANO_W-1:0]  nano_part;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              run_last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit_pct;
    logic emit_char;
    logic emit_dig;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_spec;    // incoming byte is L, f or N
    logic pct_hold;   // incoming byte is a percent that is not final
    logic cnt_zero;
    logic dig_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

[hw/rtl/sfe_datapath.sv]
// Datapath: item latch, divide-by-ten digit converter, digit buffer and output register.
`default_nettype none
module sfe_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sfe_pkg::in_item_t in_data_i,
  input  wire sfe_pkg::ctrl_cmd_t cmd_i,
  output sfe_pkg::dp_status_t    status_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output sfe_pkg::out_item_t     out_data_o
);
  import sfe_pkg::*;

  logic [CHAR_W-1:0]  char_q;
  logic [FRAC_W-1:0]  value_q, value_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   last_idx_q, last_idx_d;
  logic [DIGIT_W-1:0] digit_q [NUM_DIGITS];

  logic [MILLI_W-1:0] milli_sat;
  logic [MICRO_W-1:0] micro_sat;
  logic [NANO_W-1:0]  nano_sat;

  logic [PROD_W-1:0]  prod;
  logic [FRAC_W-1:0]  quot;
  logic [FRAC_W-1:0]  times10;
  logic [FRAC_W-1:0]  rem_full;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] cur_digit;

  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;
  logic      out_free;

  assign milli_sat = (in_data_i.milli_part > MILLI_MAX) ? MILLI_MAX : in_data_i.milli_part;
  assign micro_sat = (in_data_i.micro_part > MICRO_MAX) ? MICRO_MAX : in_data_i.micro_part;
  assign nano_sat  = (in_data_i.nano_part  > NANO_MAX)  ? NANO_MAX  : in_data_i.nano_part;

  // fraction and digit count selected by the specifier byte
  always_comb begin
    value_d    = '0;
    last_idx_d = '0;
    case (in_data_i.style_char)
      CHAR_L: begin
        value_d    = {{(FRAC_W-MILLI_W){1'b0}}, milli_sat};
        last_idx_d = MILLI_LAST;
      end
      CHAR_F: begin
        value_d    = {{(FRAC_W-MICRO_W){1'b0}}, micro_sat};
        last_idx_d = MICRO_LAST;
      end
      CHAR_N: begin
        value_d    = nano_sat;
        last_idx_d = NANO_LAST;
      end
      default: begin
        value_d    = '0;
        last_idx_d = '0;
      end
    endcase
  end

  // one decimal digit per step, least significant first
  assign prod     = PROD_W'(value_q) * PROD_W'(RECIP10);
  assign quot     = {{(FRAC_W-QUOT_W){1'b0}}, prod[PROD_W-1:RECIP_SHIFT]};
  assign times10  = (quot << 3) + (quot << 1);
  assign rem_full = value_q - times10;
  assign rem      = rem_full[DIGIT_W-1:0];

  assign cur_digit = digit_q[cnt_q];

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      cnt_d = last_idx_d;
    end else if (cmd_i.conv_step) begin
      // stays at zero after the last step, ready to emit from the top digit
      cnt_d = (cnt_q == '0) ? '0 : cnt_q - 1'b1;
    end else if (cmd_i.emit_dig) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (cmd_i.emit_pct) begin
      out_valid_d         = 1'b1;
      out_data_d.out_char = CHAR_PCT;
      out_data_d.run_last = 1'b0;
    end else if (cmd_i.emit_char) begin
      out_valid_d         = 1'b1;
      out_data_d.out_char = char_q;
      out_data_d.run_last = 1'b1;
    end else if (cmd_i.emit_dig) begin
      out_valid_d         = 1'b1;
      out_data_d.out_char = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit};
      out_data_d.run_last = (cnt_q == last_idx_q);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (cmd_i.load) begin
      char_q     <= in_data_i.style_char;
      value_q    <= value_d;
      last_idx_q <= last_idx_d;
    end else if (cmd_i.conv_step) begin
      value_q        <= quot;
      digit_q[cnt_q] <= rem;
    end
  end

  assign status_o.is_spec  = (in_data_i.style_char == CHAR_L) ||
                             (in_data_i.style_char == CHAR_F) ||
                             (in_data_i.style_char == CHAR_N);
  assign status_o.pct_hold = (in_data_i.style_char == CHAR_PCT) && !in_data_i.string_end;
  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.dig_last = (cnt_q == last_idx_q);
  assign status_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

[hw/rtl/sfe_ctrl.sv]
// Controller: sequences accept, conversion and emission of each item.
`default_nettype none
module sfe_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire sfe_pkg::dp_status_t status_i,
  output sfe_pkg::ctrl_cmd_t       cmd_o
);
  import sfe_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_PCT  = 5'b00100,
    S_CHAR = 5'b01000,
    S_DIG  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   pending_q, pending_d;

  always_comb begin
    state_d   = state_q;
    pending_d = pending_q;
    cmd_o     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (pending_q) begin
            pending_d = 1'b0;
            state_d   = status_i.is_spec ? S_CONV : S_PCT;
          end else if (status_i.pct_hold) begin
            pending_d = 1'b1;
          end else begin
            state_d = S_CHAR;
          end
        end
      end
      S_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (status_i.cnt_zero) begin
          state_d = S_DIG;
        end
      end
      S_PCT: begin
        if (status_i.out_free) begin
          cmd_o.emit_pct = 1'b1;
          state_d        = S_CHAR;
        end
      end
      S_CHAR: begin
        if (status_i.out_free) begin
          cmd_o.emit_char = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_DIG: begin
        if (status_i.out_free) begin
          cmd_o.emit_dig = 1'b1;
          if (status_i.dig_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pending_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/subsecond_format_expander.sv]
// Top level of the sub-second format expander.
`default_nettype none
`include "subsecond_format_expander_macros.svh"
// Expands %L, %f and %N in a format string, one input byte per item, into 3, 6 or 9
// zero-padded digits of the millisecond, microsecond or nanosecond fraction (values
// above range saturate to all nines). A percent not at string end is held back and
// emits nothing; a percent at string end, or any other byte, passes through. Steps:
// an ordinary byte is accepted, then emitted; a held percent is only accepted; a
// percent followed by a plain byte has the second item accepted, then the percent
// and the byte emitted; a specifier is accepted, then takes n conversion steps for
// n digits through the divide-by-ten reciprocal multiplier, least significant digit
// first, then n digit emissions. Output stalls hold the emit steps; the output
// register lets the last byte of an item wait while the next item is accepted.
module subsecond_format_expander (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sfe_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sfe_pkg::out_item_t      out_data_o
);
  import sfe_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sfe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // emission only into a free output register
  `SFE_ASSERT_IMPL(a_emit_free, clk_i, rst_ni, cmd.emit_pct || cmd.emit_char || cmd.emit_dig, status.out_free)
  // while a non-final byte of an item leaves, that item is still being worked on
  `SFE_ASSERT_IMPL(a_busy_mid_item, clk_i, rst_ni, out_valid_o && !out_stall_i && !out_data_o.run_last, in_stall_o)
  // emitting the final digit returns the block to accepting
  `SFE_ASSERT_NEXT(a_idle_after_digits, clk_i, rst_ni, cmd.emit_dig && status.dig_last, !in_stall_o)

endmodule
`default_nettype wire
